// ===== hw/rtl/lrt_pkg.sv =====
// ----------------------------------------------------------------------------
// lrt_pkg
// Shared types and constants of the lru replacement tracker.
// ----------------------------------------------------------------------------
package lrt_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 32;
  localparam int KEY_W        = 32;
  localparam int STATUS_W     = 2;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_ACCESS = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  typedef struct packed {
    opcode_t          opcode;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    victim_key;
    logic                victim_valid;
  } res_t;

endpackage

// ===== hw/rtl/lrt_table.sv =====
// ----------------------------------------------------------------------------
// lrt_table
// Key table with per-entry recency rank, updated once per transaction.
// ----------------------------------------------------------------------------
module lrt_table #(
  parameter int ENTRIES  = lrt_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lrt_pkg::KEY_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          do_op,
  input  lrt_pkg::req_t req,
  output lrt_pkg::res_t res
);

  localparam int KeyW = lrt_pkg::KEY_W;
  localparam int KW   = (KEY_BITS < KeyW) ? KEY_BITS : KeyW;
  localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW   = $clog2(ENTRIES + 1);

  logic [KW-1:0]      keys [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [AW-1:0]      age [ENTRIES];
  logic [CW-1:0]      count;

  logic [KW-1:0]      keys_next [ENTRIES];
  logic [ENTRIES-1:0] valid_next;
  logic [AW-1:0]      age_next [ENTRIES];
  logic [CW-1:0]      count_next;

  logic [KW-1:0]      kin;
  logic [ENTRIES-1:0] hit;
  logic               hit_any;
  logic [AW-1:0]      hit_age;
  logic [ENTRIES-1:0] free_oh;
  logic               full;
  logic               touch;
  logic               insert;
  logic               drop;
  logic [lrt_pkg::STATUS_W-1:0] status;
  logic [AW-1:0]      last;
  logic [KW-1:0]      vkey;

  assign kin     = req.key[KW-1:0];
  assign free_oh = ~valid & (valid + 1'b1);
  assign full    = &valid;
  assign hit_any = |hit;

  always_comb begin
    hit_age = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit[i] = valid[i] && (keys[i] == kin);
      if (hit[i]) begin
        hit_age = hit_age | age[i];
      end
    end
  end

  always_comb begin
    status = lrt_pkg::STATUS_OK;
    touch  = 1'b0;
    insert = 1'b0;
    drop   = 1'b0;
    case (req.opcode)
      lrt_pkg::OP_ADD: begin
        if (hit_any) begin
          touch = 1'b1;
        end else if (full) begin
          status = lrt_pkg::STATUS_FULL;
        end else begin
          insert = 1'b1;
        end
      end
      lrt_pkg::OP_ACCESS: begin
        if (hit_any) begin
          touch = 1'b1;
        end else begin
          status = lrt_pkg::STATUS_NOT_FOUND;
        end
      end
      lrt_pkg::OP_REMOVE: begin
        if (hit_any) begin
          drop = 1'b1;
        end else begin
          status = lrt_pkg::STATUS_NOT_FOUND;
        end
      end
      default: begin
        status = lrt_pkg::STATUS_NOT_FOUND;
      end
    endcase
  end

  always_comb begin
    valid_next = valid;
    count_next = count;
    for (int i = 0; i < ENTRIES; i++) begin
      keys_next[i] = keys[i];
      age_next[i]  = age[i];
      if (touch) begin
        if (hit[i]) begin
          age_next[i] = '0;
        end else if (valid[i] && (age[i] < hit_age)) begin
          age_next[i] = age[i] + 1'b1;
        end
      end
      if (insert) begin
        if (valid[i]) begin
          age_next[i] = age[i] + 1'b1;
        end else if (free_oh[i]) begin
          valid_next[i] = 1'b1;
          keys_next[i]  = kin;
          age_next[i]   = '0;
        end
      end
      if (drop) begin
        if (hit[i]) begin
          valid_next[i] = 1'b0;
          age_next[i]   = '0;
        end else if (valid[i] && (age[i] > hit_age)) begin
          age_next[i] = age[i] - 1'b1;
        end
      end
    end
    if (insert) begin
      count_next = count + 1'b1;
    end else if (drop) begin
      count_next = count - 1'b1;
    end
  end

  // least recent entry holds the highest rank, count - 1
  always_comb begin
    last = AW'(count_next - 1'b1);
    vkey = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_next[i] && (age_next[i] == last)) begin
        vkey = vkey | keys_next[i];
      end
    end
    res.status       = status;
    res.victim_key   = KeyW'(vkey);
    res.victim_valid = (count_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age[i] <= '0;
      end
    end else if (do_op) begin
      valid <= valid_next;
      count <= count_next;
      for (int i = 0; i < ENTRIES; i++) begin
        age[i] <= age_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_op) begin
      for (int i = 0; i < ENTRIES; i++) begin
        keys[i] <= keys_next[i];
      end
    end
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    count == CW'($countones(valid)))
    else $error("entry count out of step with valid bits");

  a_keys_distinct: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit))
    else $error("key present in more than one entry");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    do_op && (req.opcode == lrt_pkg::OP_ADD) && !hit_any && full |=> $stable(valid))
    else $error("dropped add changed the table");

  a_touch_keeps_set: assert property (@(posedge clk) disable iff (rst)
    do_op && touch |=> $stable(valid) && $stable(count))
    else $error("refresh changed the set of entries");

endmodule

// ===== hw/rtl/lru_replacement_tracker.sv =====
// ----------------------------------------------------------------------------
// lru_replacement_tracker
// Recency tracker for up to ENTRIES keys with eviction candidate output.
// ----------------------------------------------------------------------------
// input channel: in_valid / in_ready, carrying opcode (add, access, remove)
// and key. output channel: out_valid / out_ready, carrying status,
// victim_key and victim_valid, one result per input transaction.
// a transaction is captured in an input register, the table update and the
// search for the least recent key then run into the result register once
// that register can advance (out_valid low or out_ready high).
// throughput is one transaction per cycle while out_ready stays high; the
// rank compare and update over all entries is combinational.
// when out_ready is low the result register holds, the input register still
// takes one more transaction, then in_ready drops until the result is taken.
// reset (rst, synchronous) empties the table and both registers; no
// clearing pass is needed, the first transaction may follow at once.
// ----------------------------------------------------------------------------
module lru_replacement_tracker #(
  parameter int ENTRIES  = lrt_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lrt_pkg::KEY_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     opcode,
  input  logic [lrt_pkg::KEY_W-1:0]      key,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lrt_pkg::STATUS_W-1:0]   status,
  output logic [lrt_pkg::KEY_W-1:0]      victim_key,
  output logic                           victim_valid
);

  logic          req_valid;
  lrt_pkg::req_t req;
  lrt_pkg::res_t res;
  lrt_pkg::res_t res_q;
  logic          adv;
  logic          do_op;

  assign adv      = !out_valid || out_ready;
  assign in_ready = !req_valid || adv;
  assign do_op    = req_valid && adv;

  lrt_table #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .do_op (do_op),
    .req   (req),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        req_valid <= in_valid;
      end
      if (adv) begin
        out_valid <= req_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req.opcode <= lrt_pkg::opcode_t'(opcode);
      req.key    <= key;
    end
    if (do_op) begin
      res_q <= res;
    end
  end

  assign status       = res_q.status;
  assign victim_key   = res_q.victim_key;
  assign victim_valid = res_q.victim_valid;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lru replacement tracker. A directed table walks
// empty-table lookups, refresh of a present key, removal down to empty and a
// fill to capacity with a dropped add, then biased random traffic over a small
// key pool drives fill, drain and mixed phases. Results are compared field by
// field against typed row values or an in-bench recency-rank predictor, with
// random idling on both channels, a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int NUM_ENTRIES = lrt_pkg::ENTRIES_DEF;
  localparam int RAND_ITEMS  = 1750;
  localparam int POOL_SIZE   = 24;
  localparam int HOLD_CYCLES = 60;

  typedef struct {
    lrt_pkg::opcode_t          op;
    logic [lrt_pkg::KEY_W-1:0] key;
    bit                        typed;
    lrt_pkg::res_t             res;
  } dir_row_t;

  logic                         clk          = 1'b0;
  logic                         rst          = 1'b1;
  logic                         in_valid     = 1'b0;
  logic                         in_ready;
  logic [1:0]                   opcode       = lrt_pkg::OP_NOP;
  logic [lrt_pkg::KEY_W-1:0]    key          = '0;
  logic                         out_valid;
  logic                         out_ready    = 1'b0;
  logic [lrt_pkg::STATUS_W-1:0] status;
  logic [lrt_pkg::KEY_W-1:0]    victim_key;
  logic                         victim_valid;

  // predictor copy of the table
  logic [lrt_pkg::KEY_W-1:0] tbl_key   [NUM_ENTRIES];
  bit                        tbl_valid [NUM_ENTRIES];
  int                        tbl_age   [NUM_ENTRIES];

  lrt_pkg::res_t             expected_results[$];
  lrt_pkg::res_t             want_res;
  logic [lrt_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
  int                        mismatches = 0;
  bit                        calm       = 1'b0;
  bit                        hold_req   = 1'b0;

  dir_row_t dir_rows [26] = '{
    '{lrt_pkg::OP_ACCESS, 32'h0000_0000, 1'b1,
      '{lrt_pkg::STATUS_NOT_FOUND, 32'h0000_0000, 1'b0}},
    '{lrt_pkg::OP_REMOVE, 32'h0000_0000, 1'b1,
      '{lrt_pkg::STATUS_NOT_FOUND, 32'h0000_0000, 1'b0}},
    '{lrt_pkg::OP_NOP,    32'hFFFF_FFFF, 1'b1,
      '{lrt_pkg::STATUS_NOT_FOUND, 32'h0000_0000, 1'b0}},
    '{lrt_pkg::OP_ADD,    32'h0000_0000, 1'b1,
      '{lrt_pkg::STATUS_OK,        32'h0000_0000, 1'b1}},
    '{lrt_pkg::OP_ADD,    32'hFFFF_FFFF, 1'b1,
      '{lrt_pkg::STATUS_OK,        32'h0000_0000, 1'b1}},
    '{lrt_pkg::OP_ACCESS, 32'h0000_0000, 1'b1,
      '{lrt_pkg::STATUS_OK,        32'hFFFF_FFFF, 1'b1}},
    '{lrt_pkg::OP_ADD,    32'hFFFF_FFFF, 1'b1,
      '{lrt_pkg::STATUS_OK,        32'h0000_0000, 1'b1}},
    '{lrt_pkg::OP_REMOVE, 32'h0000_0000, 1'b1,
      '{lrt_pkg::STATUS_OK,        32'hFFFF_FFFF, 1'b1}},
    '{lrt_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b1,
      '{lrt_pkg::STATUS_OK,        32'h0000_0000, 1'b0}},
    '{lrt_pkg::OP_ADD, 32'h0000_0001, 1'b0, '{lrt_pkg::STATUS_OK, 32'h0000_0000, 1'b0}},
    '{lrt_pkg::OP_ADD, 32'h0000_0002, 1'b0, '{lrt_pkg::STATUS_OK, 32'h0000_0000, 1'b0}},
    '{lrt_pkg::OP_ADD, 32'h0000_0003, 1'b0, '{lrt_pkg::STATUS_OK, 32'h0000_0000, 1'b0}},
    '{lrt_pkg::OP_ADD, 32'h0000_0004, 1'b0, '{lrt_pkg::STATUS_OK, 32'h0000_0000, 1'b0}},
    '{lrt_pkg::OP_ADD, 32'h0000_0005, 1'b0, '{lrt_pkg::STATUS_OK, 32'h0000_0000, 1'b0}},
    '{lrt_pkg::OP_ADD, 32'h0000_0006, 1'b0, '{lrt_pkg::STATUS_OK, 32'h0000_0000, 1'b0}},
    '{lrt_pkg::OP_ADD, 32'h0000_0007, 1'b0, '{lrt_pkg::STATUS_OK, 32'h0000_0000, 1'b0}},
    '{lrt_pkg::OP_ADD, 32'h0000_0008, 1'b0, '{lrt_pkg::STATUS_OK, 32'h0000_0000, 1'b0}},
    '{lrt_pkg::OP_ADD, 32'h0000_0009, 1'b0, '{lrt_pkg::STATUS_OK, 32'h0000_0000, 1'b0}},
    '{lrt_pkg::OP_ADD, 32'h0000_000A, 1'b0, '{lrt_pkg::STATUS_OK, 32'h0000_0000, 1'b0}},
    '{lrt_pkg::OP_ADD, 32'h0000_000B, 1'b0, '{lrt_pkg::STATUS_OK, 32'h0000_0000, 1'b0}},
    '{lrt_pkg::OP_ADD, 32'h0000_000C, 1'b0, '{lrt_pkg::STATUS_OK, 32'h0000_0000, 1'b0}},
    '{lrt_pkg::OP_ADD, 32'h0000_000D, 1'b0, '{lrt_pkg::STATUS_OK, 32'h0000_0000, 1'b0}},
    '{lrt_pkg::OP_ADD, 32'h0000_000E, 1'b0, '{lrt_pkg::STATUS_OK, 32'h0000_0000, 1'b0}},
    '{lrt_pkg::OP_ADD, 32'h0000_000F, 1'b0, '{lrt_pkg::STATUS_OK, 32'h0000_0000, 1'b0}},
    '{lrt_pkg::OP_ADD, 32'h0000_0010, 1'b0, '{lrt_pkg::STATUS_OK, 32'h0000_0000, 1'b0}},
    '{lrt_pkg::OP_ADD, 32'h0000_0011, 1'b1,
      '{lrt_pkg::STATUS_FULL,      32'h0000_0001, 1'b1}}
  };

  lru_replacement_tracker i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .key          (key),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .victim_key   (victim_key),
    .victim_valid (victim_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic lrt_pkg::res_t lru_update(input logic [1:0] op,
                                               input logic [lrt_pkg::KEY_W-1:0] k);
    lrt_pkg::res_t r;
    int            hit;
    int            free_idx;
    int            old_age;
    int            oldest;
    r        = '{lrt_pkg::STATUS_OK, '0, 1'b0};
    hit      = -1;
    free_idx = -1;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (hit < 0 && tbl_valid[i] && tbl_key[i] == k) hit = i;
      if (free_idx < 0 && !tbl_valid[i]) free_idx = i;
    end
    if ((op == lrt_pkg::OP_ADD || op == lrt_pkg::OP_ACCESS) && hit >= 0) begin
      // refresh: younger entries age by one
      old_age = tbl_age[hit];
      for (int i = 0; i < NUM_ENTRIES; i++)
        if (tbl_valid[i] && tbl_age[i] < old_age) tbl_age[i]++;
      tbl_age[hit] = 0;
    end else if (op == lrt_pkg::OP_ADD) begin
      if (free_idx < 0) begin
        r.status = lrt_pkg::STATUS_FULL;
      end else begin
        for (int i = 0; i < NUM_ENTRIES; i++)
          if (tbl_valid[i]) tbl_age[i]++;
        tbl_valid[free_idx] = 1'b1;
        tbl_key[free_idx]   = k;
        tbl_age[free_idx]   = 0;
      end
    end else if (op == lrt_pkg::OP_REMOVE && hit >= 0) begin
      old_age = tbl_age[hit];
      for (int i = 0; i < NUM_ENTRIES; i++)
        if (tbl_valid[i] && tbl_age[i] > old_age) tbl_age[i]--;
      tbl_valid[hit] = 1'b0;
      tbl_key[hit]   = '0;
      tbl_age[hit]   = 0;
    end else begin
      r.status = lrt_pkg::STATUS_NOT_FOUND;
    end
    oldest = -1;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_age[i] > oldest) begin
        oldest         = tbl_age[i];
        r.victim_key   = tbl_key[i];
        r.victim_valid = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic offer_item(input lrt_pkg::opcode_t op,
                            input logic [lrt_pkg::KEY_W-1:0] k,
                            input bit typed, input lrt_pkg::res_t typed_res);
    lrt_pkg::res_t model_res;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    key      <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_res = lru_update(op, k);
    expected_results.push_back(typed ? typed_res : model_res);
  endtask

  task automatic log_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch (%s): got st=%0d vk=%h vv=%0d, want st=%0d vk=%h vv=%0d",
               $realtime, what, status, victim_key, victim_valid,
               want_res.status, want_res.victim_key, want_res.victim_valid);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_results.size() == 0) begin
        want_res = '{lrt_pkg::STATUS_OK, '0, 1'b0};
        log_mismatch("no transaction pending");
      end else begin
        want_res = expected_results.pop_front();
        if (status !== want_res.status || victim_key !== want_res.victim_key ||
            victim_valid !== want_res.victim_valid)
          log_mismatch("field");
      end
    end
  end

  // output side
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= calm || $urandom_range(0, 99) >= 21;
      end
    end
  end

  // input side
  initial begin
    lrt_pkg::opcode_t          op;
    logic [lrt_pkg::KEY_W-1:0] k;
    int                        r;
    int                        add_pct;
    int                        rem_pct;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      tbl_key[i]   = '0;
      tbl_valid[i] = 1'b0;
      tbl_age[i]   = 0;
    end
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h0000_0001;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    add_pct = 40;
    rem_pct = 25;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      offer_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].res);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // phase mix: fill, drain or balanced
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       begin add_pct = 65; rem_pct = 8;  end
          1:       begin add_pct = 12; rem_pct = 60; end
          default: begin add_pct = 40; rem_pct = 25; end
        endcase
      end
      calm = (n >= 400 && n < 600);
      if (n == 800) hold_req = 1'b1;
      if (n == 1300) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (r < 4)                          op = lrt_pkg::OP_NOP;
      else if (r < 4 + add_pct)           op = lrt_pkg::OP_ADD;
      else if (r < 4 + add_pct + rem_pct) op = lrt_pkg::OP_REMOVE;
      else                                op = lrt_pkg::OP_ACCESS;
      if ($urandom_range(0, 99) < 6) k = $urandom;
      offer_item(op, k, 1'b0, '{lrt_pkg::STATUS_OK, '0, 1'b0});
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
